// ----- src/tfp_pkg.sv -----
package tfp_pkg;

  // frame header bytes
  localparam logic [7:0] HdrSync = 8'hAA;
  localparam logic [7:0] HdrAddr = 8'hFF;
  localparam logic [7:0] HdrFunc = 8'hF1;

  // default limit on words per frame
  localparam int unsigned MaxWordsDef = 7;

  // widths of the payload fields
  localparam int unsigned WordW  = 16;
  localparam int unsigned CountW = 3;
  localparam int unsigned ByteW  = 8;

  // most bytes one word can produce: header, length, two data, two checksums
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned IdxW     = $clog2(MaxBytes);
  localparam int unsigned CntW     = $clog2(MaxBytes + 1);

  // byte group handed from the build stage to the serializer
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]                cnt;
    logic                           last;
  } tfp_pack_t;

endpackage

// ----- src/tfp_word_if.sv -----
interface tfp_word_if;
  logic                            valid;
  logic                            ready;
  logic [tfp_pkg::WordW-1:0]       data_word;
  logic [tfp_pkg::CountW-1:0]      word_count;

  modport source (output valid, output data_word, output word_count, input ready);
  modport sink   (input valid, input data_word, input word_count, output ready);
endinterface

// ----- src/tfp_byte_if.sv -----
interface tfp_byte_if;
  logic                       valid;
  logic                       ready;
  logic [tfp_pkg::ByteW-1:0]  out_byte;
  logic                       frame_end;

  modport source (output valid, output out_byte, output frame_end, input ready);
  modport sink   (input valid, input out_byte, input frame_end, output ready);
endinterface

// ----- src/tfp_build.sv -----
module tfp_build #(
  parameter int unsigned MaxWords = tfp_pkg::MaxWordsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tfp_word_if.sink           word_i,
  output tfp_pkg::tfp_pack_t pack_o,
  output logic               pack_valid_o,
  input  logic               pack_ready_i
);

  localparam int unsigned WlW = $clog2(MaxWords + 1);

  logic [WlW-1:0]     words_left_q, words_left_d;
  logic [7:0]         sum_q, sum_d;
  logic [7:0]         add_q, add_d;
  logic               pack_valid_q;
  tfp_pkg::tfp_pack_t pack_q, pack_d;
  logic               accept;

  assign word_i.ready = !pack_valid_q || pack_ready_i;
  assign accept       = word_i.valid && word_i.ready;
  assign pack_o       = pack_q;
  assign pack_valid_o = pack_valid_q;

  always_comb begin
    logic           open;
    logic [WlW-1:0] cnt_sat;
    logic [2:0]     n_sum;
    logic [5:0][7:0] sb;
    logic [7:0]     s, a;
    logic [7:0]     lo, hi;

    open = (words_left_q == '0);
    lo   = word_i.data_word[7:0];
    hi   = word_i.data_word[15:8];

    if (word_i.word_count == '0) begin
      cnt_sat = WlW'(1);
    end else if (32'(word_i.word_count) > MaxWords) begin
      cnt_sat = WlW'(MaxWords);
    end else begin
      cnt_sat = WlW'(word_i.word_count);
    end

    sb = '0;
    if (open) begin
      sb[0] = tfp_pkg::HdrSync;
      sb[1] = tfp_pkg::HdrAddr;
      sb[2] = tfp_pkg::HdrFunc;
      sb[3] = 8'({cnt_sat, 1'b0});
      sb[4] = lo;
      sb[5] = hi;
      n_sum = 3'd6;
      s     = '0;
      a     = '0;
    end else begin
      sb[0] = lo;
      sb[1] = hi;
      n_sum = 3'd2;
      s     = sum_q;
      a     = add_q;
    end

    // running checksums over the summed bytes of this word
    for (int i = 0; i < 6; i++) begin
      if (i < int'(n_sum)) begin
        s = s + sb[i];
        a = a + s;
      end
    end

    words_left_d = (open ? cnt_sat : words_left_q) - WlW'(1);
    sum_d        = s;
    add_d        = a;

    pack_d.bytes = '0;
    for (int i = 0; i < 6; i++) begin
      pack_d.bytes[i] = sb[i];
    end
    pack_d.last = (words_left_d == '0);
    if (pack_d.last) begin
      pack_d.bytes[n_sum]              = s;
      pack_d.bytes[3'(n_sum + 3'd1)]   = a;
    end
    pack_d.cnt = tfp_pkg::CntW'(n_sum) + (pack_d.last ? tfp_pkg::CntW'(2) : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_left_q <= '0;
      sum_q        <= '0;
      add_q        <= '0;
      pack_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        words_left_q <= words_left_d;
        sum_q        <= sum_d;
        add_q        <= add_d;
        pack_valid_q <= 1'b1;
      end else if (pack_ready_i) begin
        pack_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pack_q <= pack_d;
    end
  end

endmodule

// ----- src/tfp_serial.sv -----
module tfp_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfp_pkg::tfp_pack_t pack_i,
  input  logic               pack_valid_i,
  output logic               pack_ready_o,
  tfp_byte_if.source         byte_o
);

  tfp_pkg::tfp_pack_t             buf_q;
  logic [tfp_pkg::IdxW-1:0]       idx_q;
  logic                           busy_q;
  logic                           last_byte;
  logic                           fire;

  assign last_byte    = ({1'b0, idx_q} == (buf_q.cnt - tfp_pkg::CntW'(1)));
  assign fire         = busy_q && byte_o.ready;
  assign pack_ready_o = !busy_q || (fire && last_byte);

  assign byte_o.valid     = busy_q;
  assign byte_o.out_byte  = buf_q.bytes[idx_q];
  assign byte_o.frame_end = buf_q.last && last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (pack_ready_o) begin
        busy_q <= pack_valid_i;
        idx_q  <= '0;
      end else if (fire) begin
        idx_q <= idx_q + tfp_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pack_ready_o && pack_valid_i) begin
      buf_q <= pack_i;
    end
  end

endmodule

// ----- src/telemetry_frame_packer.sv -----
// telemetry frame packer
// word_i takes one request per handshake: a 16-bit data_word and the frame's
// word_count (1..7, read only on the first word of a frame; 0 counts as 1,
// values above MaxWords are clipped). byte_o sends the frame one byte per
// request in transmit order: sync 0xAA, 0xFF, 0xF1, length (2 x words), data
// low byte then high byte for each word, then the byte sum and the sum of sums.
// frame_end is high on the last checksum byte only.
// with the serializer idle, the first byte of a word is offered once its byte
// group has passed the build register and the serializer buffer.
// each word takes as many byte handshakes on byte_o as it yields bytes:
// 2 for a middle word, up to 8 for a one-word frame; the byte link sets the
// pace of the word stream inside a frame.
// a word is taken while the previous word's bytes are still going out: the
// build stage register holds the next byte group until the serializer frees.
// reset closes any open frame, clears both checksums and drops pending bytes.
// when the receiver stalls, byte_o holds its byte steady and word_i drops
// ready once the build register is full.
module telemetry_frame_packer #(
  parameter int unsigned MaxWords = tfp_pkg::MaxWordsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tfp_word_if.sink   word_i,
  tfp_byte_if.source byte_o
);

  // byte group for one word, registered between the two stages
  tfp_pkg::tfp_pack_t pack;
  logic               pack_valid;
  logic               pack_ready;

  // build stage: frame state, checksums and the bytes of each word
  tfp_build #(
    .MaxWords (MaxWords)
  ) u_build (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_i       (word_i),
    .pack_o       (pack),
    .pack_valid_o (pack_valid),
    .pack_ready_i (pack_ready)
  );

  // serializer: one byte per request on the output link
  tfp_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pack_i       (pack),
    .pack_valid_i (pack_valid),
    .pack_ready_o (pack_ready),
    .byte_o       (byte_o)
  );

endmodule

// ----- src/tfp_checker.sv -----
module tfp_checker #(
  parameter int unsigned MaxWords = tfp_pkg::MaxWordsDef
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end
);

  // bytes in the longest frame: header, length, data, two checksums
  localparam int unsigned FrameMax = 2 * MaxWords + 6;
  localparam int unsigned PosW     = $clog2(FrameMax);

  logic [PosW-1:0] pos_q;
  logic            fire;

  assign fire = out_valid && out_ready;

  // byte position within the current frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (fire) begin
      pos_q <= frame_end ? '0 : pos_q + PosW'(1);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(frame_end))
    else $error("output changed while stalled");

  a_sync_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pos_q == '0 |-> out_byte == tfp_pkg::HdrSync)
    else $error("frame does not open with sync byte");

  a_addr_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && pos_q == PosW'(1) |-> out_byte == tfp_pkg::HdrAddr)
    else $error("second byte is not the address byte");

  a_frame_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && frame_end |-> pos_q >= PosW'(7) && pos_q <= PosW'(FrameMax - 1))
    else $error("frame length out of range");

endmodule

bind telemetry_frame_packer tfp_checker #(
  .MaxWords (MaxWords)
) u_tfp_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (byte_o.valid),
  .out_ready (byte_o.ready),
  .out_byte  (byte_o.out_byte),
  .frame_end (byte_o.frame_end)
);

// ----- sim/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // one byte of a frame as it should appear on byte_o
  typedef struct packed {
    logic [tfp_pkg::ByteW-1:0] value;
    logic                      last;
  } frame_byte_t;

  // which side of the link is allowed to idle
  typedef enum logic [1:0] {
    IdleNone,
    IdleSender,
    IdleReceiver,
    IdleBoth
  } idle_mode_e;

  // scoreboard: rebuilds each frame from the accepted words and holds the
  // bytes still owed by the block
  class frame_scoreboard;
    logic [tfp_pkg::CountW-1:0] words_left;
    logic [tfp_pkg::ByteW-1:0]  byte_sum;
    logic [tfp_pkg::ByteW-1:0]  sum_of_sums;
    frame_byte_t                owed_bytes[$];
    int unsigned                errors;
    int unsigned                words_noted;
    int unsigned                bytes_checked;
    int unsigned                frames_closed;

    function new();
      words_left    = '0;
      byte_sum      = '0;
      sum_of_sums   = '0;
      errors        = 0;
      words_noted   = 0;
      bytes_checked = 0;
      frames_closed = 0;
    endfunction

    // a header or data byte: it goes into both checksums
    function void push_summed(logic [tfp_pkg::ByteW-1:0] b);
      byte_sum    = byte_sum + b;
      sum_of_sums = sum_of_sums + byte_sum;
      owed_bytes.push_back('{value: b, last: 1'b0});
    endfunction

    // accepted word request: work out every byte it causes
    function void note_word(logic [tfp_pkg::WordW-1:0] data,
                            logic [tfp_pkg::CountW-1:0] count);
      int unsigned words;
      words_noted++;
      if (words_left == '0) begin
        // a fresh frame samples the count: zero means one word, clip at the limit
        words = (count == '0) ? 1 : count;
        if (words > tfp_pkg::MaxWordsDef) words = tfp_pkg::MaxWordsDef;
        words_left  = words[tfp_pkg::CountW-1:0];
        byte_sum    = '0;
        sum_of_sums = '0;
        push_summed(tfp_pkg::HdrSync);
        push_summed(tfp_pkg::HdrAddr);
        push_summed(tfp_pkg::HdrFunc);
        push_summed(8'(words * 2));
      end
      push_summed(data[7:0]);
      push_summed(data[15:8]);
      words_left = words_left - 1'b1;
      if (words_left == '0) begin
        owed_bytes.push_back('{value: byte_sum, last: 1'b0});
        owed_bytes.push_back('{value: sum_of_sums, last: 1'b1});
        frames_closed++;
      end
    endfunction

    task report(string what, logic [tfp_pkg::ByteW-1:0] got,
                logic [tfp_pkg::ByteW-1:0] want);
      $display("[%0t] mismatch: %s got 0x%02h want 0x%02h", $realtime, what, got, want);
      errors++;
    endtask

    task check_byte(logic [tfp_pkg::ByteW-1:0] b, logic fend);
      frame_byte_t want;
      bytes_checked++;
      if (owed_bytes.size() == 0) begin
        report("byte with nothing owed", b, '0);
      end else begin
        want = owed_bytes.pop_front();
        if (b !== want.value) report("out_byte", b, want.value);
        if (fend !== want.last) report("frame_end", {7'd0, fend}, {7'd0, want.last});
      end
    endtask

    function int unsigned pending();
      return owed_bytes.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tfp_word_if word_if ();
  tfp_byte_if byte_if ();

  telemetry_frame_packer DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .word_i (word_if),
    .byte_o (byte_if)
  );

  frame_scoreboard sb = new();

  idle_mode_e  idle_mode   = IdleNone;
  // long receiver hold-off: stimulus bumps hold_req, the receiver serves it
  int unsigned hold_req    = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // hard stop in case the block locks up
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  // sender side: gap chance of 88 in 100 when idling alone, 11 when both idle
  function automatic bit sender_gap();
    case (idle_mode)
      IdleSender: return $urandom_range(99) < 88;
      IdleBoth:   return $urandom_range(99) < 11;
      default:    return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stall();
    case (idle_mode)
      IdleReceiver: return $urandom_range(99) < 88;
      IdleBoth:     return $urandom_range(99) < 11;
      default:      return 1'b0;
    endcase
  endfunction

  // offer one word request and hold it until the block takes it
  task automatic send_word(logic [tfp_pkg::WordW-1:0] data,
                           logic [tfp_pkg::CountW-1:0] count);
    while (sender_gap()) begin
      word_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    word_if.valid      <= 1'b1;
    word_if.data_word  <= data;
    word_if.word_count <= count;
    do @(posedge clk_i); while (!word_if.ready);
    sb.note_word(data, count);
  endtask

  // random word with the all-zero and all-one patterns showing up often
  task automatic send_random_word();
    logic [tfp_pkg::WordW-1:0] data;
    case ($urandom_range(9))
      0:       data = '0;
      1:       data = '1;
      default: data = tfp_pkg::WordW'($urandom);
    endcase
    send_word(data, tfp_pkg::CountW'($urandom_range(7)));
  endtask

  // receiver: checks every accepted byte, then picks ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && byte_if.valid && byte_if.ready) begin
      sb.check_byte(byte_if.out_byte, byte_if.frame_end);
    end
    if (!rst_ni) begin
      byte_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      byte_if.ready <= 1'b0;
    end else if (hold_served != hold_req) begin
      // long stall so the build register fills and word_i drops ready
      hold_served = hold_req;
      hold_left   = 300;
      byte_if.ready <= 1'b0;
    end else begin
      byte_if.ready <= !receiver_stall();
    end
  end

  initial begin
    word_if.valid      <= 1'b0;
    word_if.data_word  <= '0;
    word_if.word_count <= '0;
    rst_ni             <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: one-word frame at the low extremes
    send_word(16'h0000, 3'd1);
    // zero count behaves as a one-word frame
    send_word(16'hFFFF, 3'd0);
    // longest frame; the count on later words must be ignored
    send_word(16'h1234, 3'd7);
    send_word(16'hFFFF, 3'd0);
    send_word(16'h0000, 3'd7);
    send_word(16'h00FF, 3'd1);
    send_word(16'hFF00, 3'd3);
    send_word(16'h8001, 3'd5);
    send_word(16'h7FFE, 3'd2);
    // all-ones data so both checksums wrap several times
    send_word(16'hFFFF, 3'd2);
    send_word(16'hFFFF, 3'd6);
    // alternating bit patterns over a three-word frame
    send_word(16'hA5A5, 3'd3);
    send_word(16'h5A5A, 3'd4);
    send_word(16'h0001, 3'd0);

    // back-to-back words into a receiver that stops for a long stretch
    hold_req++;
    repeat (16) send_random_word();

    // random words under each idling pattern, starting with none
    for (int ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      repeat (20) send_random_word();
    end
    word_if.valid <= 1'b0;

    // drain everything owed, then keep watching for stray bytes
    idle_mode = IdleNone;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("covered %0d words in %0d frames, %0d bytes checked",
             sb.words_noted, sb.frames_closed, sb.bytes_checked);
    $display("idling: none, sender only, receiver only, both, plus one long receiver hold");
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
